FILE: rtl/mfek_pkg.sv
// Shared types and constants for the Edmonds-Karp max flow block.
`default_nettype none
package mfek_pkg;
    localparam int CMD_W  = 2;
    localparam int VTX_W  = 4;
    localparam int CAPI_W = 16;
    localparam int FLOW_W = 20;
    localparam int CFGI_W = 2;
    localparam int CFGD_W = 5;

    localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_RUN   = 2'd2;

    localparam logic [CFGI_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_SOURCE       = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_SINK         = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/mfek_cmd_if.sv
// Valid/ready channel carrying one command item.
`default_nettype none
interface mfek_cmd_if
    import mfek_pkg::*;
;
    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [VTX_W-1:0]  from_vertex;
    logic [VTX_W-1:0]  to_vertex;
    logic [CAPI_W-1:0] capacity;

    modport source (output valid, command, from_vertex, to_vertex, capacity, input ready);
    modport sink   (input valid, command, from_vertex, to_vertex, capacity, output ready);
endinterface
`default_nettype wire

FILE: rtl/mfek_res_if.sv
// Valid/ready channel carrying one max flow result.
`default_nettype none
interface mfek_res_if
    import mfek_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FLOW_W-1:0] flow_sum;

    modport source (output valid, flow_sum, input ready);
    modport sink   (input valid, flow_sum, output ready);
endinterface
`default_nettype wire

FILE: rtl/max_flow_edmonds_karp.sv
// Edmonds-Karp max flow engine over a capacity matrix held in block memory.
`default_nettype none
// Commands transfer one per cycle while the engine is idle. A clear, and the
// sweep after reset, write zero to every capacity entry, one per cycle, with no
// input taken. A run copies the capacity memory into the residual memory, then
// repeats breadth-first searches; each dequeued vertex takes one residual read
// per neighbor over the single read port, and each augmenting path edge passes
// through S_ARF, S_ARB and S_AWB for the read-modify-write of the forward and
// backward residuals. The result waits in an output register; new commands
// transfer while it waits.
module max_flow_edmonds_karp
    import mfek_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int CAP_WIDTH    = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [CFGI_W-1:0]   i_cfg_idx,
    input  wire [CFGD_W-1:0]   i_cfg_wdata,
    mfek_cmd_if.sink           i_cmd,
    mfek_res_if.source         o_res
);
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = VW + 1;
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int KW    = AW + 1;
    localparam int RW    = CAP_WIDTH + 1;
    localparam int CMPW  = VW + 6;
    localparam int SUMW  = ((RW > FLOW_W) ? RW : FLOW_W) + 1;
    localparam logic [RW-1:0] NO_LIMIT = '1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_COPY = 4'd2;
    localparam logic [3:0] S_INIT = 4'd3;
    localparam logic [3:0] S_POP  = 4'd4;
    localparam logic [3:0] S_SCAN = 4'd5;
    localparam logic [3:0] S_ARF  = 4'd6;
    localparam logic [3:0] S_ARB  = 4'd7;
    localparam logic [3:0] S_AWB  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [CAP_WIDTH-1:0] r_cap_mem [DEPTH];
    logic [RW-1:0]        r_res_mem [DEPTH];
    logic [CAP_WIDTH-1:0] r_cap_q;
    logic [RW-1:0]        r_res_q;

    logic [CFGD_W-1:0] r_vertex_count;
    logic [VTX_W-1:0]  r_src, r_dst;

    logic [3:0]        r_state, n_state;
    logic [KW-1:0]     r_k, n_k;
    logic [VW-1:0]     r_u, n_u;
    logic [VW-1:0]     r_p, n_p;
    logic [NW-1:0]     r_v, n_v;
    logic [NW-1:0]     r_head, n_head;
    logic [NW-1:0]     r_tail, n_tail;
    logic [RW-1:0]     r_lim, n_lim;
    logic [RW-1:0]     r_m, n_m;
    logic [FLOW_W-1:0] r_total, n_total;
    logic              r_chk, n_chk;
    logic [VW-1:0]     r_chk_v, n_chk_v;
    logic              r_ov, n_ov;
    logic [FLOW_W-1:0] r_flow, n_flow;

    logic [MAX_VERTICES-1:0] r_vis;
    logic [VW-1:0]           r_par [MAX_VERTICES];
    logic [VW-1:0]           r_qv  [MAX_VERTICES];
    logic [RW-1:0]           r_ql  [MAX_VERTICES];

    logic                 cap_we, cap_re, res_we, res_re;
    logic [AW-1:0]        cap_wa, cap_ra, res_wa, res_ra;
    logic [CAP_WIDTH-1:0] cap_wd;
    logic [RW-1:0]        res_wd;
    logic                 q_init, q_push, vis_set;

    logic [NW-1:0]   n_eff;
    logic [VW-1:0]   src_idx, dst_idx, par_u;
    logic            terms_bad, wr_ok, hit, hit_dst;
    logic [RW-1:0]   mval;
    logic [SUMW-1:0] sum;

    always_comb begin
        if (r_vertex_count == '0) begin
            n_eff = NW'(1);
        end else if (CMPW'(r_vertex_count) > CMPW'(MAX_VERTICES)) begin
            n_eff = NW'(MAX_VERTICES);
        end else begin
            n_eff = NW'(r_vertex_count);
        end
    end

    assign src_idx   = VW'(r_src);
    assign dst_idx   = VW'(r_dst);
    assign terms_bad = (CMPW'(r_src) >= CMPW'(n_eff)) || (CMPW'(r_dst) >= CMPW'(n_eff))
                       || (r_src == r_dst);
    assign wr_ok     = (CMPW'(i_cmd.from_vertex) < CMPW'(MAX_VERTICES))
                       && (CMPW'(i_cmd.to_vertex) < CMPW'(MAX_VERTICES));
    assign hit       = r_chk && (r_chk_v != r_u) && !r_vis[r_chk_v] && (r_res_q != '0);
    assign hit_dst   = hit && (r_chk_v == dst_idx);
    assign mval      = (r_res_q < r_lim) ? r_res_q : r_lim;
    assign sum       = SUMW'(r_total) + SUMW'(mval);
    assign par_u     = r_par[r_u];

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_ov;
    assign o_res.flow_sum = r_flow;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_u     = r_u;
        n_p     = r_p;
        n_v     = r_v;
        n_head  = r_head;
        n_tail  = r_tail;
        n_lim   = r_lim;
        n_m     = r_m;
        n_total = r_total;
        n_chk   = 1'b0;
        n_chk_v = r_chk_v;
        n_ov    = r_ov && !o_res.ready;
        n_flow  = r_flow;
        cap_we  = 1'b0;
        cap_wa  = AW'(r_k);
        cap_wd  = '0;
        cap_re  = 1'b0;
        cap_ra  = AW'(r_k);
        res_we  = 1'b0;
        res_wa  = '0;
        res_wd  = '0;
        res_re  = 1'b0;
        res_ra  = '0;
        q_init  = 1'b0;
        q_push  = 1'b0;
        vis_set = 1'b0;
        case (r_state)
            S_CLR: begin
                cap_we = 1'b1;
                n_k    = r_k + KW'(1);
                if (r_k == KW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    case (i_cmd.command)
                        CMD_CLEAR: begin
                            n_k     = '0;
                            n_state = S_CLR;
                        end
                        CMD_WRITE: begin
                            cap_we = wr_ok;
                            cap_wa = {VW'(i_cmd.from_vertex), VW'(i_cmd.to_vertex)};
                            cap_wd = CAP_WIDTH'(i_cmd.capacity);
                        end
                        CMD_RUN: begin
                            n_total = '0;
                            n_k     = '0;
                            n_state = terms_bad ? S_FIN : S_COPY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COPY: begin
                cap_re = (r_k < KW'(DEPTH));
                res_we = (r_k != '0);
                res_wa = AW'(r_k - KW'(1));
                res_wd = RW'(r_cap_q);
                n_k    = r_k + KW'(1);
                if (r_k == KW'(DEPTH)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                q_init  = 1'b1;
                n_head  = '0;
                n_tail  = NW'(1);
                n_state = S_POP;
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    n_state = S_FIN;
                end else begin
                    n_u     = r_qv[VW'(r_head)];
                    n_lim   = r_ql[VW'(r_head)];
                    n_head  = r_head + NW'(1);
                    n_v     = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                vis_set = hit;
                if (hit_dst) begin
                    n_m     = mval;
                    n_u     = dst_idx;
                    n_total = (sum > SUMW'(FLOW_MAX)) ? FLOW_MAX : FLOW_W'(sum);
                    n_state = S_ARF;
                end else begin
                    q_push = hit && (r_tail < NW'(MAX_VERTICES));
                    if (q_push) begin
                        n_tail = r_tail + NW'(1);
                    end
                    if (r_v < n_eff) begin
                        res_re  = 1'b1;
                        res_ra  = {r_u, VW'(r_v)};
                        n_chk   = 1'b1;
                        n_chk_v = VW'(r_v);
                        n_v     = r_v + NW'(1);
                    end else if (!r_chk) begin
                        n_state = S_POP;
                    end
                end
            end
            S_ARF: begin
                res_re  = 1'b1;
                res_ra  = {par_u, r_u};
                n_p     = par_u;
                n_state = S_ARB;
            end
            S_ARB: begin
                res_re  = 1'b1;
                res_ra  = {r_u, r_p};
                res_we  = 1'b1;
                res_wa  = {r_p, r_u};
                res_wd  = r_res_q - r_m;
                n_state = S_AWB;
            end
            S_AWB: begin
                res_we  = 1'b1;
                res_wa  = {r_u, r_p};
                res_wd  = r_res_q + r_m;
                n_u     = r_p;
                n_state = (r_p == src_idx) ? S_INIT : S_ARF;
            end
            S_FIN: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_flow  = r_total;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cap_we) begin
            r_cap_mem[cap_wa] <= cap_wd;
        end
        if (cap_re) begin
            r_cap_q <= r_cap_mem[cap_ra];
        end
        if (res_we) begin
            r_res_mem[res_wa] <= res_wd;
        end
        if (res_re) begin
            r_res_q <= r_res_mem[res_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_init) begin
            r_qv[0] <= src_idx;
            r_ql[0] <= NO_LIMIT;
        end
        if (q_push) begin
            r_qv[VW'(r_tail)] <= r_chk_v;
            r_ql[VW'(r_tail)] <= mval;
        end
        if (vis_set) begin
            r_par[r_chk_v] <= r_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis <= '0;
        end else if (q_init) begin
            r_vis <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << src_idx;
        end else if (vis_set) begin
            r_vis[r_chk_v] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CFGD_W'(16);
            r_src          <= '0;
            r_dst          <= VTX_W'(15);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_wdata;
                CFG_SOURCE:       r_src          <= VTX_W'(i_cfg_wdata);
                CFG_SINK:         r_dst          <= VTX_W'(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_k     <= '0;
            r_chk   <= 1'b0;
            r_ov    <= 1'b0;
            r_total <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_chk   <= n_chk;
            r_ov    <= n_ov;
            r_total <= n_total;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
        r_u     <= n_u;
        r_p     <= n_p;
        r_v     <= n_v;
        r_lim   <= n_lim;
        r_m     <= n_m;
        r_chk_v <= n_chk_v;
        r_flow  <= n_flow;
    end

`ifndef ASSERT_OFF
    a_res_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the finish step");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= NW'(MAX_VERTICES))
        else $error("search queue overrun");
    a_aug_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ARF |-> r_m != '0)
        else $error("augmenting with zero bottleneck");
    a_no_self_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ARB |-> r_p != r_u)
        else $error("augmenting path takes a self-loop");
`endif
endmodule
`default_nettype wire
